// ----- rtl/mfp_pkg.sv -----
// Package for the frame parser: payload types, phase codes, constants and the CRC step.
package mfp_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam logic [7:0] START_V1 = 8'hFE;
    localparam logic [7:0] START_V2 = 8'hFD;
    localparam logic [7:0] V1_HDR_BYTES = 8'd6;
    localparam logic [7:0] V1_CRC_BYTES = 8'd2;
    localparam logic [7:0] V2_HEADER_BYTES = 8'd10;
    localparam logic [7:0] SIGNATURE_BYTES = 8'd13;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TABLE = 1'b1;
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END = 1'b1;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_CRC_BAD = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT, PH_HEADER, PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI, PH_SIG
    } t_phase;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  rx_byte;
        logic [3:0]  entry_index;
        logic [23:0] entry_msgid;
        logic [7:0]  entry_crc_extra;
        logic        entry_valid;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_offset;
        logic [1:0]  status;
        logic        version;
        logic [23:0] frame_msgid;
        logic [7:0]  frame_seq;
        logic [7:0]  frame_sysid;
        logic [7:0]  frame_compid;
        logic [7:0]  frame_len;
        logic        signed_frame;
    } t_out_item;

    typedef struct packed {
        logic       known;
        logic [7:0] extra;
    } t_lookup;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

// ----- rtl/mfp_extra_table.sv -----
// CRC-extra table: valid bits, ids and extra bytes with a priority match.
module mfp_extra_table import mfp_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [3:0]  i_wr_index,
    input  logic [23:0] i_wr_msgid,
    input  logic [7:0]  i_wr_extra,
    input  logic        i_wr_valid,
    input  logic [23:0] i_look_msgid,
    output t_lookup     o_look
);

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [23:0] r_id    [TABLE_ENTRIES];
    logic [7:0]  r_extra [TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (i_wr_en && 32'(i_wr_index) == i) begin
                    r_valid[i] <= i_wr_valid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i_wr_en && 32'(i_wr_index) == i) begin
                r_id[i]    <= i_wr_msgid;
                r_extra[i] <= i_wr_extra;
            end
        end
    end

    // lowest matching slot wins: scan from the top down
    always_comb begin
        o_look = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_id[i] == i_look_msgid) begin
                o_look.known = 1'b1;
                o_look.extra = r_extra[i];
            end
        end
    end

endmodule

// ----- rtl/mavlink_frame_parser.sv -----
// Top level of the byte-serial v1/v2 frame parser.
// The parser takes one transfer per cycle unless held: a stream byte (opcode 0) or a CRC-extra
// table write (opcode 1). Each stream byte passes through the input register and the header/CRC
// logic into the result register, from which its result is offered, so a byte follows a byte
// with no gap. The X.25 CRC step and the 16-way table compare form the logic between the two
// registers; input is held only while a result waits for the receiver. Payload bytes
// come out as kind 0 with their offset; every frame closes with one kind 1 transfer carrying
// the header and status (ok, unknown id, CRC mismatch). Bytes outside a frame other than
// 0xFE/0xFD are dropped; a signed v2 frame's 13-byte signature is skipped unchecked.
// Table writes take effect for frames whose last id byte arrives after the write.
module mavlink_frame_parser import mfp_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    // input stage
    logic     r_in_vld;
    t_in_item r_in;
    logic     stall;

    // parse state
    t_phase      r_phase, n_phase;
    logic        r_v2, n_v2;
    logic        r_sig, n_sig;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_sys, n_sys;
    logic [7:0]  r_comp, n_comp;
    logic [23:0] r_id, n_id;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crclo, n_crclo;
    logic        r_known, n_known;
    logic [7:0]  r_extra, n_extra;

    logic        res_vld;
    t_out_item   res;
    logic        r_out_vld;
    t_out_item   r_out;
    t_lookup     look;
    logic [23:0] id_final;
    logic [7:0]  b;
    logic        do_step;

    // hold the input stage while the result register is full and not drained
    assign stall   = r_out_vld && !i_ready;
    assign o_ready = !stall;
    assign do_step = r_in_vld && !stall;
    assign b       = r_in.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall && i_valid) begin
            r_in <= i_data;
        end
    end

    // id after the current header byte, for the lookup on the last id byte
    assign id_final = r_v2 ? {b, r_id[15:0]} : {16'h0000, b};

    mfp_extra_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (do_step && r_in.opcode == OP_TABLE
                       && 32'(r_in.entry_index) < TABLE_ENTRIES),
        .i_wr_index   (r_in.entry_index),
        .i_wr_msgid   (r_in.entry_msgid),
        .i_wr_extra   (r_in.entry_crc_extra),
        .i_wr_valid   (r_in.entry_valid),
        .i_look_msgid (id_final),
        .o_look       (look)
    );

    // next state
    always_comb begin
        n_phase = r_phase; n_v2 = r_v2; n_sig = r_sig; n_len = r_len; n_cnt = r_cnt;
        n_seq = r_seq; n_sys = r_sys; n_comp = r_comp; n_id = r_id; n_crc = r_crc;
        n_crclo = r_crclo; n_known = r_known; n_extra = r_extra;
        if (do_step && r_in.opcode == OP_BYTE) begin
            case (r_phase)
                PH_HEADER: begin
                    n_crc = crc_step(r_crc, b);
                    if (r_cnt == 8'd1) n_len = b;
                    if (!r_v2) begin
                        case (r_cnt)
                            8'd1: ;
                            8'd2: n_seq = b;
                            8'd3: n_sys = b;
                            8'd4: n_comp = b;
                            default: n_id = {16'h0000, b};
                        endcase
                    end else begin
                        case (r_cnt)
                            8'd1, 8'd3: ;
                            8'd2: n_sig = b[0];
                            8'd4: n_seq = b;
                            8'd5: n_sys = b;
                            8'd6: n_comp = b;
                            8'd7: n_id = {16'h0000, b};
                            8'd8: n_id = {r_id[23:16], b, r_id[7:0]};
                            default: n_id = {b, r_id[15:0]};
                        endcase
                    end
                    if (r_cnt >= (r_v2 ? V2_HEADER_BYTES - 8'd1 : V1_HDR_BYTES - 8'd1)) begin
                        n_known = look.known;
                        n_extra = look.extra;
                        n_cnt   = '0;
                        n_phase = (n_len == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
                    end else begin
                        n_cnt = r_cnt + 8'd1;
                    end
                end
                PH_PAYLOAD: begin
                    n_crc = crc_step(r_crc, b);
                    n_cnt = r_cnt + 8'd1;
                    if (n_cnt == r_len) n_phase = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    n_crc   = crc_step(r_crc, r_extra);
                    n_crclo = b;
                    n_phase = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    n_crc = r_crc ^ {b, r_crclo};
                    if (r_v2 && r_sig) begin
                        n_cnt   = '0;
                        n_phase = PH_SIG;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_SIG: begin
                    n_cnt = r_cnt + 8'd1;
                    if (n_cnt >= SIGNATURE_BYTES) n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (b == START_V1 || b == START_V2) begin
                        n_v2 = (b == START_V2);
                        n_sig = 1'b0; n_len = '0; n_seq = '0; n_sys = '0; n_comp = '0;
                        n_id = '0; n_crc = 16'hFFFF; n_crclo = '0; n_known = 1'b0;
                        n_extra = '0; n_cnt = 8'd1;
                        n_phase = PH_HEADER;
                    end
                end
            endcase
        end
    end

    // result of the current byte
    always_comb begin
        res_vld = 1'b0;
        res = '0;
        res.version      = r_v2;
        res.frame_msgid  = r_id;
        res.frame_seq    = r_seq;
        res.frame_sysid  = r_sys;
        res.frame_compid = r_comp;
        res.frame_len    = r_len;
        res.signed_frame = r_sig;
        if (do_step && r_in.opcode == OP_BYTE) begin
            case (r_phase)
                PH_PAYLOAD: begin
                    res_vld = 1'b1;
                    res.kind = KIND_DATA;
                    res.data_byte = b;
                    res.byte_offset = r_cnt;
                end
                PH_CRC_HI, PH_SIG: begin
                    if (n_phase == PH_HUNT) begin
                        res_vld = 1'b1;
                        res.kind = KIND_END;
                        res.status = !r_known ? ST_UNKNOWN :
                                     (n_crc != 16'h0000 ? ST_CRC_BAD : ST_OK);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT; r_v2 <= 1'b0; r_sig <= 1'b0; r_len <= '0; r_cnt <= '0;
            r_seq <= '0; r_sys <= '0; r_comp <= '0; r_id <= '0; r_crc <= 16'hFFFF;
            r_crclo <= '0; r_known <= 1'b0; r_extra <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_phase <= n_phase; r_v2 <= n_v2; r_sig <= n_sig; r_len <= n_len; r_cnt <= n_cnt;
            r_seq <= n_seq; r_sys <= n_sys; r_comp <= n_comp; r_id <= n_id; r_crc <= n_crc;
            r_crclo <= n_crclo; r_known <= n_known; r_extra <= n_extra;
            if (!stall) r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) r_out <= res;
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

`ifndef ASSERT_OFF
    // a held result must not change while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |=> (r_out_vld && $stable(r_out)))
        else $error("result changed under stall");
    // frame end always returns to hunting
    a_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_vld && res.kind == KIND_END) |=> (r_phase == PH_HUNT))
        else $error("frame end without return to hunt");
    // payload results only come from the payload phase
    a_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_vld && res.kind == KIND_DATA) |-> (r_phase == PH_PAYLOAD && r_cnt < r_len))
        else $error("payload result outside payload");
    // the signature phase exists only for signed v2 frames
    a_sig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SIG) |-> (r_v2 && r_sig))
        else $error("signature skip on unsigned frame");
`endif

endmodule

// ----- verif/tb_mavlink_frame_parser.sv -----
// Self-checking testbench for the MAVLink v1/v2 frame parser.
module tb_mavlink_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import mfp_pkg::*;

    localparam int N_SLOTS = TABLE_ENTRIES_DEF;
    localparam int STALL_LIMIT = 5000;

    // Tracks the parser state and holds the frame results still owed by the block.
    class frame_scoreboard;
        t_out_item owed[$];
        int errors;
        logic [23:0] tab_id[N_SLOTS];
        logic [7:0] tab_extra[N_SLOTS];
        bit tab_ok[N_SLOTS];
        t_phase phase;
        bit v2, sig, known;
        logic [7:0] plen, cnt, seq, sysid, compid, extra, crc_lo;
        logic [23:0] msgid;
        logic [15:0] crc;

        function new();
            errors = 0;
            phase = PH_HUNT;
            for (int i = 0; i < N_SLOTS; i++) tab_ok[i] = 0;
        endfunction

        function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
            logic [7:0] t;
            t = b ^ c[7:0];
            t = t ^ (t << 4);
            return (c >> 8) ^ (16'(t) << 8) ^ (16'(t) << 3) ^ (16'(t) >> 4);
        endfunction

        function void owe(logic k, logic [7:0] d, logic [7:0] off, logic [1:0] st);
            t_out_item r;
            r.kind = k; r.data_byte = d; r.byte_offset = off; r.status = st;
            r.version = v2; r.frame_msgid = msgid; r.frame_seq = seq;
            r.frame_sysid = sysid; r.frame_compid = compid; r.frame_len = plen;
            r.signed_frame = sig;
            owed.push_back(r);
        endfunction

        function void close_frame();
            owe(KIND_END, 8'd0, 8'd0, !known ? ST_UNKNOWN : (crc != 0 ? ST_CRC_BAD : ST_OK));
            phase = PH_HUNT;
        endfunction

        function void note_input(t_in_item it);
            logic [7:0] b;
            if (it.opcode == OP_TABLE) begin
                if (it.entry_index < N_SLOTS) begin
                    tab_id[it.entry_index] = it.entry_msgid;
                    tab_extra[it.entry_index] = it.entry_crc_extra;
                    tab_ok[it.entry_index] = it.entry_valid;
                end
                return;
            end
            b = it.rx_byte;
            case (phase)
                PH_HEADER: begin
                    crc = crc_next(crc, b);
                    if (!v2) begin
                        case (cnt)
                            1: plen = b;
                            2: seq = b;
                            3: sysid = b;
                            4: compid = b;
                            default: msgid = {16'd0, b};
                        endcase
                    end else begin
                        case (cnt)
                            1: plen = b;
                            2: sig = b[0];
                            3: ;
                            4: seq = b;
                            5: sysid = b;
                            6: compid = b;
                            7: msgid = {16'd0, b};
                            8: msgid[15:8] = b;
                            default: msgid[23:16] = b;
                        endcase
                    end
                    if (cnt >= (v2 ? V2_HEADER_BYTES - 1 : V1_HDR_BYTES - 1)) begin
                        known = 0; extra = 0;
                        for (int i = 0; i < N_SLOTS; i++)
                            if (!known && tab_ok[i] && tab_id[i] == msgid) begin
                                known = 1; extra = tab_extra[i];
                            end
                        cnt = 0;
                        phase = (plen == 0) ? PH_CRC_LO : PH_PAYLOAD;
                    end else cnt++;
                end
                PH_PAYLOAD: begin
                    crc = crc_next(crc, b);
                    owe(KIND_DATA, b, cnt, ST_OK);
                    cnt++;
                    if (cnt == plen) phase = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    crc = crc_next(crc, extra);
                    crc_lo = b;
                    phase = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    crc = crc ^ {b, crc_lo};
                    if (v2 && sig) begin
                        cnt = 0; phase = PH_SIG;
                    end else close_frame();
                end
                PH_SIG: begin
                    cnt++;
                    if (cnt >= SIGNATURE_BYTES) close_frame();
                end
                default: begin
                    if (b == START_V1 || b == START_V2) begin
                        v2 = (b == START_V2);
                        sig = 0; plen = 0; seq = 0; sysid = 0; compid = 0; msgid = 0;
                        crc = 16'hFFFF; crc_lo = 0; known = 0; extra = 0;
                        cnt = 1; phase = PH_HEADER;
                    end
                end
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_result(t_out_item got);
            t_out_item w;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            w = owed.pop_front();
            if (got.kind !== w.kind) report("kind");
            if (got.data_byte !== w.data_byte) report("data_byte");
            if (got.byte_offset !== w.byte_offset) report("byte_offset");
            if (got.status !== w.status) report("status");
            if (got.version !== w.version) report("version");
            if (got.frame_msgid !== w.frame_msgid) report("frame_msgid");
            if (got.frame_seq !== w.frame_seq) report("frame_seq");
            if (got.frame_sysid !== w.frame_sysid) report("frame_sysid");
            if (got.frame_compid !== w.frame_compid) report("frame_compid");
            if (got.frame_len !== w.frame_len) report("frame_len");
            if (got.signed_frame !== w.signed_frame) report("signed_frame");
        endtask
    endclass

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    t_in_item i_data;
    t_out_item o_data;

    mavlink_frame_parser i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    frame_scoreboard sb = new();
    int idle_pct = 25;      // idle odds per side, in percent
    bit hold_off = 0;       // receiver stall on demand
    int quiet_cycles = 0;
    logic [23:0] known_ids[$];
    t_in_item stream_q[$];  // bytes lined up for the sender

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Score every transfer at the rising edge; count cycles with no transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_input(i_data);
            if (o_valid && i_ready) sb.check_result(o_data);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, plus a forced hold-off while hold_off is set.
    initial begin
        i_ready = 0;
        forever begin
            @(negedge i_clk);
            i_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog.
    initial begin
        forever begin
            @(posedge i_clk);
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Offer one item, with a random gap first, and wait for its transfer.
    // Starts and ends at a falling edge; valid stays up for a following item.
    task send(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_data <= it;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task put_byte(logic [7:0] b);
        t_in_item it;
        it = $urandom;
        it.opcode = OP_BYTE;
        it.rx_byte = b;
        stream_q.push_back(it);
    endtask

    task flush_stream();
        while (stream_q.size() > 0) send(stream_q.pop_front());
        i_valid <= 0;
    endtask

    task write_slot(logic [3:0] idx, logic [23:0] id, logic [7:0] ext, logic ok);
        t_in_item it;
        it = $urandom;
        it.opcode = OP_TABLE;
        it.entry_index = idx; it.entry_msgid = id;
        it.entry_crc_extra = ext; it.entry_valid = ok;
        send(it);
    endtask

    // Line up one frame; the CRC is right unless corrupted, using the extra byte given.
    task build_frame(bit v2, logic [7:0] len, logic [23:0] id, logic [7:0] ext,
                     bit signd, bit corrupt);
        logic [7:0] hdr[$];
        logic [15:0] c;
        logic [7:0] pb;
        c = 16'hFFFF;
        hdr.push_back(len);
        if (v2) begin
            hdr.push_back({7'($urandom_range(127)), signd});
            hdr.push_back(8'($urandom));
        end
        hdr.push_back(8'($urandom)); hdr.push_back(8'($urandom)); hdr.push_back(8'($urandom));
        hdr.push_back(id[7:0]);
        if (v2) begin
            hdr.push_back(id[15:8]); hdr.push_back(id[23:16]);
        end
        put_byte(v2 ? START_V2 : START_V1);
        foreach (hdr[k]) begin
            c = sb.crc_next(c, hdr[k]); put_byte(hdr[k]);
        end
        for (int k = 0; k < len; k++) begin
            pb = $urandom; c = sb.crc_next(c, pb); put_byte(pb);
        end
        c = sb.crc_next(c, ext);
        if (corrupt) c ^= 16'(1) << $urandom_range(15);
        put_byte(c[7:0]); put_byte(c[15:8]);
        if (v2 && signd) for (int k = 0; k < SIGNATURE_BYTES; k++) put_byte(8'($urandom));
    endtask

    task random_frame();
        bit v2;
        logic [23:0] id;
        logic [7:0] len, ext;
        bit hit;
        v2 = $urandom_range(1);
        hit = $urandom_range(9) < 8 && known_ids.size() > 0;
        id = hit ? known_ids[$urandom_range(known_ids.size() - 1)] : 24'($urandom);
        if (!v2) id[23:8] = 0;
        ext = 0;
        for (int i = N_SLOTS - 1; i >= 0; i--)
            if (sb.tab_ok[i] && sb.tab_id[i] == id) ext = sb.tab_extra[i];
        len = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(12));
        if (!$urandom_range(9)) repeat ($urandom_range(4)) put_byte(8'($urandom));
        build_frame(v2, len, id, ext, $urandom_range(1), $urandom_range(9) == 0);
    endtask

    // Wait for all owed results plus the pipeline depth.
    task drain();
        while (sb.owed.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: table extremes, duplicates, both versions, zero and max length,
        // unknown id, bad CRC, signed frame, noise while hunting, disabled slot.
        write_slot(4'd0, 24'h000000, 8'h00, 1);
        write_slot(4'd15, 24'hFFFFFF, 8'hFF, 1);
        write_slot(4'd3, 24'h0000FF, 8'h5A, 1);
        write_slot(4'd4, 24'h0000FF, 8'hA5, 1);   // duplicate, lower slot wins
        write_slot(4'd5, 24'h000042, 8'h11, 0);   // disabled slot
        put_byte(8'h00); put_byte(8'hFF); put_byte(8'h55);
        build_frame(0, 8'd0, 24'h0000FF, 8'h5A, 0, 0);
        build_frame(1, 8'd3, 24'hFFFFFF, 8'hFF, 1, 0);
        build_frame(1, 8'd255, 24'h000000, 8'h00, 0, 0);
        build_frame(0, 8'd2, 24'h000042, 8'h11, 0, 0);
        build_frame(1, 8'd1, 24'hFFFFFF, 8'hFF, 0, 1);
        build_frame(0, 8'd4, 24'h0000FE, 8'h00, 0, 0);
        flush_stream();
        known_ids = '{24'h000000, 24'hFFFFFF, 24'h0000FF};

        // Random phase with table reloads at idle points.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            idle_pct = (ph == 2) ? 0 : 25;
            repeat (6) begin
                logic [23:0] id;
                logic [3:0] idx;
                id = ($urandom_range(1)) ? 24'($urandom_range(255)) : 24'($urandom);
                idx = $urandom;
                write_slot(idx, id, $urandom, $urandom_range(3) != 0);
                known_ids.push_back(id);
            end
            if (ph == 3) begin
                // Long receiver hold-off while the sender keeps offering.
                hold_off = 1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            while (stream_q.size() < 260) random_frame();
            flush_stream();
        end

        drain();
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
